// ===== src/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, constants and marker helpers for the marker frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

   // Frame geometry
   localparam int PAYLOAD_BYTES = 32;
   localparam int MARK_LEN      = 3;
   localparam int MAX_OUT       = 32;
   localparam int OUT_CAP       = (PAYLOAD_BYTES < MAX_OUT) ? PAYLOAD_BYTES : MAX_OUT;
   localparam int POS_W         = (PAYLOAD_BYTES > 4) ? $clog2(PAYLOAD_BYTES) : 2;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 6;
   localparam int MARKER_W = 24;
   localparam int CSR_AW   = 4;

   // Register map
   localparam logic [CSR_AW-1:0] REG_CHANNEL_COUNT = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_FRAME_MARKER  = CSR_AW'(1);

   // Register reset values
   localparam logic [COUNT_W-1:0]  CHANNEL_COUNT_RST = COUNT_W'(32);
   localparam logic [MARKER_W-1:0] FRAME_MARKER_RST  = 24'h383D44;

   // Parser phase
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_TAIL = 2'd2
   } phase_type;

   // Control handed to the payload chain
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] fill;
   } chain_ctl_type;

   // Pick marker byte idx, first byte in the top bits
   function automatic logic [BYTE_W-1:0] mark_byte(logic [1:0] idx,
                                                   logic [MARKER_W-1:0] mk);
      logic [BYTE_W-1:0] r;
      case (idx)
         2'd1:    r = mk[15:8];
         2'd2:    r = mk[7:0];
         default: r = mk[23:16];
      endcase
      return r;
   endfunction

   // Longest marker prefix that ends the matched prefix plus the new byte
   function automatic logic [1:0] hunt_advance(logic [1:0] k, logic [BYTE_W-1:0] b,
                                               logic [MARKER_W-1:0] mk);
      logic [BYTE_W-1:0] m0;
      logic [BYTE_W-1:0] m1;
      logic [BYTE_W-1:0] m2;
      logic [1:0]        r;
      m0 = mk[23:16];
      m1 = mk[15:8];
      m2 = mk[7:0];
      r  = 2'd0;
      case (k)
         2'd1: begin
            if (b == m1)      r = 2'd2;
            else if (b == m0) r = 2'd1;
         end
         2'd2: begin
            if (b == m2)                   r = 2'd3;
            else if (m1 == m0 && b == m1)  r = 2'd2;
            else if (b == m0)              r = 2'd1;
         end
         default: begin
            if (b == m0) r = 2'd1;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== src/mfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_if
// Valid/ready channel interfaces for received bytes, channel results and
// register writes.
// ----------------------------------------------------------------------------
interface mfd_req_if;
   logic                      valid;
   logic                      ready;
   logic [mfd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mfd_pkg::INDEX_W-1:0] channel_index;
   logic [mfd_pkg::BYTE_W-1:0]  channel_value;
   logic                       last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output last_channel, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input last_channel, output ready);
endinterface

interface mfd_csr_if;
   logic                        valid;
   logic                        ready;
   logic [mfd_pkg::CSR_AW-1:0]   addr;
   logic [mfd_pkg::MARKER_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== src/mfd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_cell
// One payload byte cell: loads its neighbour's byte when the chain shifts.
// ----------------------------------------------------------------------------
module mfd_cell (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [mfd_pkg::BYTE_W-1:0] data_in,
   output logic [mfd_pkg::BYTE_W-1:0] data_out
);

   logic [mfd_pkg::BYTE_W-1:0] data_ff;

   // Take the neighbour's byte on a shift, hold otherwise
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ===== src/mfd_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_chain
// Row of payload cells. Bytes enter at the tail and move one cell towards
// the head on each shift; the head holds the oldest stored byte.
// ----------------------------------------------------------------------------
module mfd_chain (
   input  logic                       clock,
   input  mfd_pkg::chain_ctl_type     ctl,
   output logic [mfd_pkg::BYTE_W-1:0] head
);

   logic [mfd_pkg::BYTE_W-1:0] cell_q [mfd_pkg::PAYLOAD_BYTES];

   // Build the row; the last cell takes the fill byte
   for (genvar i = 0; i < mfd_pkg::PAYLOAD_BYTES; i++) begin : g_cell
      if (i == mfd_pkg::PAYLOAD_BYTES - 1) begin : g_tail
         mfd_cell u_cell (
            .clock    (clock),
            .shift    (ctl.shift),
            .data_in  (ctl.fill),
            .data_out (cell_q[i])
         );
      end else begin : g_body
         mfd_cell u_cell (
            .clock    (clock),
            .shift    (ctl.shift),
            .data_in  (cell_q[i+1]),
            .data_out (cell_q[i])
         );
      end
   end

   assign head = cell_q[0];

endmodule

// ===== src/marker_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_frame_deframer
// Hunts for a three-byte marker, stores a fixed payload in a cell chain,
// checks the end marker and delivers the leading payload bytes as results.
// ----------------------------------------------------------------------------
// Output: the last end-marker byte loads the drain count; results then pass from
//   the chain head into the output register, one result per cycle while the result channel is ready.
// Throughput: one byte per cycle while no results drain; a good frame holds
//   input off until its channel_count results (at most 32) have drained, so result stalls extend it.
// Reset (synchronous) returns to hunting, clears counters and restores the
//   register defaults; the payload chain is not cleared.
module marker_frame_deframer (
   input  logic           clock,
   input  logic           reset,
   mfd_req_if.sink        req_ch,
   mfd_rsp_if.source      rsp_ch,
   mfd_csr_if.sink        csr_ch
);

   // Configuration registers
   logic [mfd_pkg::COUNT_W-1:0]  chan_count_ff;
   logic [mfd_pkg::MARKER_W-1:0] marker_ff;

   // Parser state
   mfd_pkg::phase_type           phase_ff, phase_in;
   logic [mfd_pkg::POS_W-1:0]    pos_ff, pos_in;

   // Result drain
   logic [mfd_pkg::COUNT_W-1:0]  emit_left_ff, emit_left_in;
   logic [mfd_pkg::INDEX_W-1:0]  emit_idx_ff, emit_idx_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mfd_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [mfd_pkg::BYTE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_xfer;
   logic                         out_load;
   logic [1:0]                   mark_pos;
   logic [1:0]                   hunt_next;
   logic [mfd_pkg::COUNT_W-1:0]  frame_cnt;
   logic [mfd_pkg::BYTE_W-1:0]   chain_head;
   mfd_pkg::chain_ctl_type       chain_ctl;

   assign req_ch.ready = (emit_left_ff == '0);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_load     = (emit_left_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);

   assign mark_pos  = pos_ff[1:0];
   assign hunt_next = mfd_pkg::hunt_advance(mark_pos, req_ch.rx_byte, marker_ff);
   assign frame_cnt = (chan_count_ff > mfd_pkg::COUNT_W'(mfd_pkg::OUT_CAP))
                      ? mfd_pkg::COUNT_W'(mfd_pkg::OUT_CAP) : chan_count_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= mfd_pkg::CHANNEL_COUNT_RST;
         marker_ff     <= mfd_pkg::FRAME_MARKER_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.addr)
            mfd_pkg::REG_CHANNEL_COUNT: chan_count_ff <= csr_ch.wdata[mfd_pkg::COUNT_W-1:0];
            mfd_pkg::REG_FRAME_MARKER:  marker_ff     <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mfd_pkg::PH_HUNT;
         pos_ff       <= '0;
         emit_left_ff <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         emit_left_ff <= emit_left_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Parser next state, drain and chain control
   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      emit_left_in    = emit_left_ff;
      emit_idx_in     = emit_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      chain_ctl.shift = 1'b0;
      chain_ctl.fill  = req_ch.rx_byte;

      if (req_xfer) begin
         unique case (phase_ff)
            mfd_pkg::PH_DATA: begin
               chain_ctl.shift = 1'b1;
               if (pos_ff == mfd_pkg::POS_W'(mfd_pkg::PAYLOAD_BYTES - 1)) begin
                  phase_in = mfd_pkg::PH_TAIL;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            mfd_pkg::PH_TAIL: begin
               if (req_ch.rx_byte == mfd_pkg::mark_byte(mark_pos, marker_ff)) begin
                  if (mark_pos == 2'(mfd_pkg::MARK_LEN - 1)) begin
                     phase_in     = mfd_pkg::PH_HUNT;
                     pos_in       = '0;
                     emit_left_in = frame_cnt;
                     emit_idx_in  = '0;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end else if (hunt_next == 2'(mfd_pkg::MARK_LEN)) begin
                  phase_in = mfd_pkg::PH_DATA;
                  pos_in   = '0;
               end else begin
                  phase_in = mfd_pkg::PH_HUNT;
                  pos_in   = mfd_pkg::POS_W'(hunt_next);
               end
            end
            default: begin
               if (hunt_next == 2'(mfd_pkg::MARK_LEN)) begin
                  phase_in = mfd_pkg::PH_DATA;
                  pos_in   = '0;
               end else begin
                  phase_in = mfd_pkg::PH_HUNT;
                  pos_in   = mfd_pkg::POS_W'(hunt_next);
               end
            end
         endcase
      end

      // Pop the chain head into the output register
      if (out_load) begin
         rsp_valid_in    = 1'b1;
         rsp_index_in    = emit_idx_ff;
         rsp_value_in    = chain_head;
         rsp_last_in     = (emit_left_ff == mfd_pkg::COUNT_W'(1));
         emit_left_in    = emit_left_ff - 1'b1;
         emit_idx_in     = emit_idx_ff + 1'b1;
         chain_ctl.shift = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   mfd_chain u_chain (
      .clock (clock),
      .ctl   (chain_ctl),
      .head  (chain_head)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.channel_index = rsp_index_ff;
   assign rsp_ch.channel_value = rsp_value_ff;
   assign rsp_ch.last_channel  = rsp_last_ff;

endmodule

// ===== src/mfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks on the result channel of the marker frame deframer.
// ----------------------------------------------------------------------------
module mfd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mfd_pkg::INDEX_W-1:0] channel_index,
   input logic [mfd_pkg::BYTE_W-1:0]  channel_value,
   input logic                        last_channel
);

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(channel_index)
         && $stable(channel_value) && $stable(last_channel))
      else $error("stalled result changed");

   // A frame's results open at channel zero
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> channel_index == '0)
      else $error("frame does not start at channel zero");

   // The top channel always closes the frame
   a_top_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && channel_index == mfd_pkg::INDEX_W'(mfd_pkg::MAX_OUT - 1)
         |-> last_channel)
      else $error("top channel not flagged last");

endmodule

bind marker_frame_deframer mfd_checker u_mfd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .channel_index (rsp_ch.channel_index),
   .channel_value (rsp_ch.channel_value),
   .last_channel  (rsp_ch.last_channel)
);
